[design/adc_scan_register_block_assert.svh]
// Assertion macros for the ADC scan register block checks.
`ifndef ADC_SCAN_REGISTER_BLOCK_ASSERT_SVH
`define ADC_SCAN_REGISTER_BLOCK_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ASRB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("adc_scan_register_block: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("adc_scan_register_block: next-cycle check failed");

`endif

[design/asrb_pkg.sv]
`default_nettype none
package asrb_pkg;

   localparam int REG_WORDS_DEF     = 2185;
   localparam int CHANNEL_SLOTS_DEF = 24;
   localparam int RESULT_SLOTS_DEF  = 23;
   localparam int SCAN_GROUPS_DEF   = 9;
   localparam int WORD_BITS         = 32;

   // register map, as word indexes (byte offset >> 2)
   localparam logic [11:0] DIAG_WORD   = 12'h080;  // 0x0200
   localparam logic [11:0] CHCFG_WORD  = 12'h180;  // 0x0600, stride 4 words
   localparam logic [11:0] FORMAT_WORD = 12'h183;  // 0x060C, stride 4 words
   localparam logic [11:0] START_WORD  = 12'h308;  // 0x0C20
   localparam logic [11:0] RESULT_WORD = 12'h800;  // 0x2000
   localparam logic [11:0] EXT_WORD    = 12'h860;  // 0x2180
   localparam logic [13:0] STATUS_OFFSET = 14'h0C80;

   localparam logic [6:0]  EXT_BASE_CHAN = 7'h60;
   localparam logic [6:0]  TEMP_CHAN     = 7'h64;
   localparam logic [4:0]  EXT_SLOTS     = 5'd23;
   localparam logic [15:0] TEMP_CODE     = 16'd1800;
   localparam logic [15:0] DEFAULT_CODE  = 16'd2048;
   localparam logic [2:0]  DIAG_HIGH     = 3'd5;
   localparam logic [2:0]  DIAG_LOW      = 3'd6;

   localparam logic ACCESS_READ  = 1'b0;
   localparam logic ACCESS_WRITE = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [13:0] byte_offset;
      logic [31:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        scan_done;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIAG,
      ST_SLOT,
      ST_FMT,
      ST_DONE
   } state_type;

   function automatic logic [15:0] midscale_code(input logic [1:0] res);
      logic [15:0] code;
      unique case (res)
         2'd0: code = 16'h8000;
         2'd1: code = 16'h2000;
         2'd2: code = 16'h0800;
         default: code = 16'h0200;
      endcase
      return code;
   endfunction

   function automatic logic [15:0] diag_code(input logic [2:0] dv);
      logic [15:0] code;
      if (dv == DIAG_HIGH) begin
         code = 16'h8000;
      end else if (dv == DIAG_LOW) begin
         code = 16'h7FFF;
      end else begin
         code = 16'h0000;
      end
      return code;
   endfunction

endpackage
`default_nettype wire

[design/adc_scan_register_block.sv]
// ADC scan register block: a word-addressed register window that answers one
// bus transfer per request (read or write, 14-bit byte offset, 32-bit data)
// with one response (read data, scan-done flag). Reads beyond the window
// return 0 and writes there are dropped; the status word at 0x0C80 reads with
// its busy bit clear. A write with bit 0 set to a group start register stores
// the word and then walks every channel slot, filling result and extended
// result registers of that group's slots with fixed codes, and answers with
// scan_done set. After reset the block clears its word store, one word per
// cycle, all REG_WORDS words (2185 by default), with req_stall high. A plain
// read or write then passes from idle to the done state, which registers the
// response once the output register is free; a scan first reads the group's
// diagnosis control, then each slot's config plus a format read where needed.
// A new request is taken as soon as the sequencer is back in idle, even while
// the previous response still waits in the output register.
`default_nettype none
module adc_scan_register_block import asrb_pkg::*; #(
   parameter int REG_WORDS     = REG_WORDS_DEF,
   parameter int CHANNEL_SLOTS = CHANNEL_SLOTS_DEF,
   parameter int RESULT_SLOTS  = RESULT_SLOTS_DEF,
   parameter int SCAN_GROUPS   = SCAN_GROUPS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_data
);

   localparam int AW = $clog2(REG_WORDS);
   localparam int SW = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;
   localparam int GW = (SCAN_GROUPS > 1) ? $clog2(SCAN_GROUPS) : 1;
   localparam int START_END = START_WORD + SCAN_GROUPS;

   // sequencer state
   state_type    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [GW-1:0] grp_ff, grp_in;
   logic [2:0]    dv_ff, dv_in;
   logic          is_read_ff, is_read_in;
   logic          in_win_ff, in_win_in;
   logic          is_status_ff, is_status_in;
   logic          done_ff, done_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_data_ff, rsp_data_in;

   // word store port
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   wr_data, rd_data;

   // request decode
   logic [11:0]   req_word;
   logic          req_in_win, req_start, out_free, advance;
   logic [GW-1:0] req_group;

   // slot config decode from the read port
   logic [4:0]    cfg_group;
   logic [6:0]    cfg_chan;
   logic [4:0]    ext_idx;
   logic          grp_match, slot_has_result, slot_last;
   logic [SW-1:0] slot_nxt;
   logic [15:0]   int_code;

   asrb_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (REG_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_word   = req_data.byte_offset[13:2];
   assign req_in_win = {1'b0, req_word} < 13'(REG_WORDS);
   assign req_group  = GW'(req_word - START_WORD);
   // start register hit: a write to any byte offset within a group's start word, bit 0 set
   assign req_start  = (req_data.req_type == ACCESS_WRITE) && req_in_win
                       && (req_word >= START_WORD)
                       && ({1'b0, req_word} < 13'(START_END))
                       && req_data.write_data[0];

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign cfg_group       = rd_data[4:0];
   assign cfg_chan        = rd_data[14:8];
   assign ext_idx         = 5'(cfg_chan - EXT_BASE_CHAN);
   assign grp_match       = (cfg_group == 5'(grp_ff));
   assign slot_has_result = int'(slot_ff) < RESULT_SLOTS;
   assign slot_last       = (slot_ff == SW'(CHANNEL_SLOTS - 1));
   assign slot_nxt        = slot_ff + SW'(1);

   // internal channel code: diagnosis, temperature sensor, or default
   always_comb begin
      if (cfg_chan == EXT_BASE_CHAN) begin
         int_code = diag_code(dv_ff);
      end else if (cfg_chan == TEMP_CHAN) begin
         int_code = TEMP_CODE;
      end else begin
         int_code = DEFAULT_CODE;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      slot_in      = slot_ff;
      grp_in       = grp_ff;
      dv_in        = dv_ff;
      is_read_in   = is_read_ff;
      in_win_in    = in_win_ff;
      is_status_in = is_status_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      advance      = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(REG_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               is_read_in   = (req_data.req_type == ACCESS_READ);
               in_win_in    = req_in_win;
               is_status_in = (req_data.byte_offset == STATUS_OFFSET);
               done_in      = 1'b0;
               grp_in       = req_group;
               slot_in      = '0;
               if ((req_data.req_type == ACCESS_WRITE) && req_in_win) begin
                  wr_en   = 1'b1;
                  wr_addr = req_word[AW-1:0];
                  wr_data = req_data.write_data;
               end
               if (req_start) begin
                  // fetch the group's diagnosis control first
                  rd_en    = 1'b1;
                  rd_addr  = AW'(DIAG_WORD) + AW'(req_group);
                  state_in = ST_DIAG;
               end else begin
                  rd_en    = (req_data.req_type == ACCESS_READ) && req_in_win;
                  rd_addr  = req_word[AW-1:0];
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIAG: begin
            dv_in    = rd_data[2:0];
            rd_en    = 1'b1;
            rd_addr  = AW'(CHCFG_WORD);
            state_in = ST_SLOT;
         end
         ST_SLOT: begin
            if (grp_match && (cfg_chan < EXT_BASE_CHAN) && slot_has_result) begin
               // ordinary channel: need the slot's resolution
               rd_en    = 1'b1;
               rd_addr  = AW'(FORMAT_WORD) + AW'({slot_ff, 2'b00});
               state_in = ST_FMT;
            end else begin
               if (grp_match && (cfg_chan >= EXT_BASE_CHAN) && (ext_idx < EXT_SLOTS)) begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(EXT_WORD) + AW'(ext_idx);
                  wr_data = {16'h0000, int_code};
               end
               advance = 1'b1;
            end
         end
         ST_FMT: begin
            wr_en   = 1'b1;
            wr_addr = AW'(RESULT_WORD) + AW'(slot_ff);
            wr_data = {16'h0000, midscale_code(rd_data[17:16])};
            advance = 1'b1;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (is_read_ff && in_win_ff) begin
                  rsp_data_in.read_data = is_status_ff ? (rd_data & ~32'h1) : rd_data;
               end else begin
                  rsp_data_in.read_data = '0;
               end
               rsp_data_in.scan_done = done_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // step to the next slot, or finish the scan
      if (advance) begin
         if (slot_last) begin
            done_in  = 1'b1;
            state_in = ST_DONE;
         end else begin
            slot_in  = slot_nxt;
            rd_en    = 1'b1;
            rd_addr  = AW'(CHCFG_WORD) + AW'({slot_nxt, 2'b00});
            state_in = ST_SLOT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      grp_ff       <= grp_in;
      dv_ff        <= dv_in;
      is_read_ff   <= is_read_in;
      in_win_ff    <= in_win_in;
      is_status_ff <= is_status_in;
      done_ff      <= done_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

[design/asrb_ram.sv]
`default_nettype none
module asrb_ram import asrb_pkg::*; #(
   parameter int WIDTH = WORD_BITS,
   parameter int DEPTH = REG_WORDS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[design/asrb_checker.sv]
`default_nettype none
`include "adc_scan_register_block_assert.svh"
module asrb_checker import asrb_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire req_item_type req_data,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_item_type rsp_data
);

   // request held while stalled
   `ASRB_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_data))
   // response held while stalled
   `ASRB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASRB_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))
   // a scan only comes from a write, so no read data with it
   `ASRB_ASSERT_SAME(a_scan_no_data, clock, reset, rsp_valid && rsp_data.scan_done, rsp_data.read_data == 32'h0)
   // store clear follows reset: no transfers, no stale response
   `ASRB_ASSERT_SAME(a_clear_after_reset, clock, reset, $past(reset), req_stall && !rsp_valid)

endmodule

bind adc_scan_register_block asrb_checker u_checker (.*);
`default_nettype wire
